// File: hdl/tcw_pkg.sv
// Shared types, codes and the microcode table for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam logic [2:0] OP_PUT       = 3'd0;
    localparam logic [2:0] OP_PUT_COLOR = 3'd1;
    localparam logic [2:0] OP_CLEAR     = 3'd2;
    localparam logic [2:0] OP_FILL      = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_BLANK   = 8'h20;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic [10:0] cursor_cell;
    } t_res;

    // Microcode steps.
    typedef enum logic [3:0] {
        PC_IDLE,
        PC_RST,
        PC_CLR,
        PC_FILL,
        PC_RD_ISSUE,
        PC_RD_DONE,
        PC_PUT_CHECK,
        PC_SCR_INIT,
        PC_SCR_LOOP,
        PC_SCR_FLUSH,
        PC_BLANK,
        PC_PUT_WRITE,
        PC_NOP
    } t_pc;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_WR_ZERO,
        MEM_WR_BLANK,
        MEM_WR_ATTR,
        MEM_RD_CELL,
        MEM_SHIFT,
        MEM_SHIFT_LAST,
        MEM_PUT
    } t_mem_op;

    typedef enum logic [1:0] {
        ADR_ZERO,
        ADR_INC,
        ADR_LD_COLS,
        ADR_LD_LAST_ROW
    } t_addr_op;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_LAST_ROW,
        CUR_PUT
    } t_cur_op;

    typedef enum logic [1:0] {
        CND_NONE,
        CND_LAST,
        CND_AT_END,
        CND_DISPATCH
    } t_cond;

    // One control word. mem and addr act every cycle of the step;
    // cur, emit and show_rd act only on the cycle the step exits via next.
    typedef struct packed {
        t_mem_op  mem;
        t_addr_op addr;
        t_cur_op  cur;
        t_cond    cond;
        t_pc      next;
        t_pc      alt;
        logic     emit;
        logic     show_rd;
    } t_ctrl;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
        logic       at_last;
        logic       at_end;
    } t_stat;

    typedef struct packed {
        t_ctrl ctrl;
        logic  taken;
        logic  busy;
    } t_seq;

    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl c;
        c = '{MEM_NONE, ADR_ZERO, CUR_HOLD, CND_NONE, PC_IDLE, PC_IDLE, 1'b0, 1'b0};
        case (pc)
            PC_IDLE: begin
                c.cond = CND_DISPATCH;
            end
            PC_RST: begin
                c = '{MEM_WR_ZERO, ADR_INC, CUR_HOLD, CND_LAST,
                      PC_IDLE, PC_RST, 1'b0, 1'b0};
            end
            PC_CLR: begin
                c = '{MEM_WR_BLANK, ADR_INC, CUR_ZERO, CND_LAST,
                      PC_IDLE, PC_CLR, 1'b1, 1'b0};
            end
            PC_FILL: begin
                c = '{MEM_WR_ATTR, ADR_INC, CUR_HOLD, CND_LAST,
                      PC_IDLE, PC_FILL, 1'b1, 1'b0};
            end
            PC_RD_ISSUE: begin
                c = '{MEM_RD_CELL, ADR_ZERO, CUR_HOLD, CND_NONE,
                      PC_RD_DONE, PC_RD_DONE, 1'b0, 1'b0};
            end
            PC_RD_DONE: begin
                c = '{MEM_NONE, ADR_ZERO, CUR_HOLD, CND_NONE,
                      PC_IDLE, PC_IDLE, 1'b1, 1'b1};
            end
            PC_PUT_CHECK: begin
                c = '{MEM_NONE, ADR_ZERO, CUR_HOLD, CND_AT_END,
                      PC_SCR_INIT, PC_PUT_WRITE, 1'b0, 1'b0};
            end
            PC_SCR_INIT: begin
                c = '{MEM_NONE, ADR_LD_COLS, CUR_HOLD, CND_NONE,
                      PC_SCR_LOOP, PC_SCR_LOOP, 1'b0, 1'b0};
            end
            PC_SCR_LOOP: begin
                c = '{MEM_SHIFT, ADR_INC, CUR_HOLD, CND_LAST,
                      PC_SCR_FLUSH, PC_SCR_LOOP, 1'b0, 1'b0};
            end
            PC_SCR_FLUSH: begin
                c = '{MEM_SHIFT_LAST, ADR_LD_LAST_ROW, CUR_HOLD, CND_NONE,
                      PC_BLANK, PC_BLANK, 1'b0, 1'b0};
            end
            PC_BLANK: begin
                c = '{MEM_WR_BLANK, ADR_INC, CUR_LAST_ROW, CND_LAST,
                      PC_PUT_WRITE, PC_BLANK, 1'b0, 1'b0};
            end
            PC_PUT_WRITE: begin
                c = '{MEM_PUT, ADR_ZERO, CUR_PUT, CND_NONE,
                      PC_IDLE, PC_IDLE, 1'b1, 1'b0};
            end
            PC_NOP: begin
                c = '{MEM_NONE, ADR_ZERO, CUR_HOLD, CND_NONE,
                      PC_IDLE, PC_IDLE, 1'b1, 1'b0};
            end
            default: begin
                c.cond = CND_NONE;
            end
        endcase
        return c;
    endfunction

    // Entry step for each operation code.
    function automatic t_pc dispatch(input logic [2:0] op);
        t_pc p;
        case (op)
            OP_PUT:       p = PC_PUT_CHECK;
            OP_PUT_COLOR: p = PC_PUT_CHECK;
            OP_CLEAR:     p = PC_CLR;
            OP_FILL:      p = PC_FILL;
            OP_READ:      p = PC_RD_ISSUE;
            default:      p = PC_NOP;
        endcase
        return p;
    endfunction

endpackage

// File: hdl/tcw_sequencer.sv
// Microcode sequencer: step counter, control table lookup and branching.
`timescale 1ns / 1ps

module tcw_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_seq  o_seq
);
    import tcw_pkg::*;

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w_ctrl;
    logic  w_taken;

    always_comb begin
        w_ctrl = ucode(r_pc);
        case (w_ctrl.cond)
            CND_NONE:     w_taken = 1'b1;
            CND_LAST:     w_taken = i_stat.at_last;
            CND_AT_END:   w_taken = i_stat.at_end;
            CND_DISPATCH: w_taken = i_stat.start;
            default:      w_taken = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        case (w_ctrl.cond)
            CND_DISPATCH: n_pc = i_stat.start ? dispatch(i_stat.op) : w_ctrl.next;
            default:      n_pc = w_taken ? w_ctrl.next : w_ctrl.alt;
        endcase
    end

    // outputs
    always_comb begin
        o_seq.ctrl  = w_ctrl;
        o_seq.taken = w_taken;
        o_seq.busy  = (r_pc != PC_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_RST;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: hdl/text_console_writer_unit.sv
// Top level of the text console writer: screen stores, cursor and datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Word
// -------   ---------  --------------------------  -----------------------------
// command   in         start high while busy low   i_cmd  (t_cmd)
// result    out        o_strobe, one cycle         o_res  (t_res), one per command
//
// Walks (CELLS = COLUMNS*ROWS): clear, fill, and the scroll of a put at the
//   end of screen. Each screen store has a single write port: every walk
//   touches one cell per cycle.
// Reset: after i_rst_n is released a zeroing pass over both stores runs with
//   busy high.
// The result strobe cannot be stalled; the next command may start in the same
//   cycle as the strobe.
module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_strobe,
    output tcw_pkg::t_res o_res
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    localparam logic [CNT_W-1:0] K_CELLS    = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] K_LAST     = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] K_COLS     = CNT_W'(COLUMNS);
    localparam logic [CNT_W-1:0] K_COLS_P1  = CNT_W'(COLUMNS + 1);
    localparam logic [CNT_W-1:0] K_LAST_ROW = CNT_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0] K_COL_MAX  = COL_W'(COLUMNS - 1);

    // Screen stores.
    logic [7:0] r_chars [CELLS];
    logic [7:0] r_attrs [CELLS];

    t_stat w_stat;
    t_seq  w_seq;
    t_ctrl w_ctrl;
    logic  w_accept;

    t_cmd             r_cmd;
    logic             r_idx_ok;
    logic [CNT_W-1:0] r_addr;
    logic [CNT_W-1:0] n_addr;
    logic [CNT_W-1:0] r_cursor;
    logic [CNT_W-1:0] n_cursor;
    logic [COL_W-1:0] r_col;      // cursor column, tracked to avoid a modulo
    logic [COL_W-1:0] n_col;
    logic [7:0]       r_rd_char;
    logic [7:0]       r_rd_attr;

    logic              w_we_char;
    logic              w_we_attr;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_wchar;
    logic [7:0]        w_wattr;
    logic [CNT_W-1:0]  w_shift_addr;
    logic              w_newline;

    assign w_accept = start && !w_seq.busy;
    assign w_ctrl   = w_seq.ctrl;
    assign busy     = w_seq.busy;

    always_comb begin
        w_stat.start   = start;
        w_stat.op      = i_cmd.operation;
        w_stat.at_last = (r_addr == K_LAST);
        w_stat.at_end  = (r_cursor == K_CELLS);
    end

    tcw_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_seq   (w_seq)
    );

    assign w_newline    = (r_cmd.char_code == CH_NEWLINE);
    // scroll writes the byte read last cycle one row up
    assign w_shift_addr = r_addr - K_COLS_P1;

    // store port control
    always_comb begin
        w_we_char = 1'b0;
        w_we_attr = 1'b0;
        w_waddr   = r_addr[ADDR_W-1:0];
        w_wchar   = CH_BLANK;
        w_wattr   = r_cmd.color;
        w_raddr   = r_addr[ADDR_W-1:0];
        case (w_ctrl.mem)
            MEM_WR_ZERO: begin
                w_we_char = 1'b1;
                w_we_attr = 1'b1;
                w_wchar   = 8'd0;
                w_wattr   = 8'd0;
            end
            MEM_WR_BLANK: begin
                w_we_char = 1'b1;
            end
            MEM_WR_ATTR: begin
                w_we_attr = 1'b1;
            end
            MEM_RD_CELL: begin
                w_raddr = ADDR_W'(r_cmd.cell_index);
            end
            MEM_SHIFT: begin
                // first cycle of the walk has nothing read yet
                w_we_char = (r_addr != K_COLS);
                w_waddr   = w_shift_addr[ADDR_W-1:0];
                w_wchar   = r_rd_char;
            end
            MEM_SHIFT_LAST: begin
                w_we_char = 1'b1;
                w_waddr   = w_shift_addr[ADDR_W-1:0];
                w_wchar   = r_rd_char;
            end
            MEM_PUT: begin
                w_we_char = !w_newline;
                w_we_attr = !w_newline && (r_cmd.operation == OP_PUT_COLOR);
                w_waddr   = r_cursor[ADDR_W-1:0];
                w_wchar   = r_cmd.char_code;
            end
            default: begin
                w_we_char = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_char) begin
            r_chars[w_waddr] <= w_wchar;
        end
        if (w_we_attr) begin
            r_attrs[w_waddr] <= w_wattr;
        end
        r_rd_char <= r_chars[w_raddr];
        r_rd_attr <= r_attrs[w_raddr];
    end

    // walk counter
    always_comb begin
        case (w_ctrl.addr)
            ADR_ZERO:        n_addr = '0;
            ADR_INC:         n_addr = r_addr + CNT_W'(1);
            ADR_LD_COLS:     n_addr = K_COLS;
            ADR_LD_LAST_ROW: n_addr = K_LAST_ROW;
            default:         n_addr = '0;
        endcase
    end

    // cursor and column
    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        if (w_seq.taken) begin
            case (w_ctrl.cur)
                CUR_ZERO: begin
                    n_cursor = '0;
                    n_col    = '0;
                end
                CUR_LAST_ROW: begin
                    n_cursor = K_LAST_ROW;
                    n_col    = '0;
                end
                CUR_PUT: begin
                    if (w_newline) begin
                        n_cursor = r_cursor + K_COLS - CNT_W'(r_col);
                        n_col    = '0;
                    end else begin
                        n_cursor = r_cursor + CNT_W'(1);
                        n_col    = (r_col == K_COL_MAX) ? '0 : r_col + COL_W'(1);
                    end
                end
                default: begin
                    n_cursor = r_cursor;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_cursor <= '0;
            r_col    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_addr   <= n_addr;
            r_cursor <= n_cursor;
            r_col    <= n_col;
            o_strobe <= w_seq.taken && w_ctrl.emit;
        end
    end

    // command word and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_idx_ok <= (32'(i_cmd.cell_index) < 32'(CELLS));
        end
        if (w_seq.taken && w_ctrl.emit) begin
            o_res.cursor_cell <= 11'(n_cursor);
            if (w_ctrl.show_rd && r_idx_ok) begin
                o_res.read_char <= r_rd_char;
                o_res.read_attr <= r_rd_attr;
            end else begin
                o_res.read_char <= 8'd0;
                o_res.read_attr <= 8'd0;
            end
        end
    end

endmodule

// File: sim/text_console_writer_unit_tb.sv
// Self-checking testbench for the text console writer: shadow screen, scoreboard, stimulus.
`timescale 1ns / 1ps

module text_console_writer_unit_tb;

    import tcw_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    // Codes with no operation behind them; the block must leave everything alone.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Largest cell_index the field can carry, used to go past the screen.
    localparam logic [10:0] INDEX_MAX = 11'h7FF;

    localparam int RANDOM_WORDS  = 300;
    // Slowest command: a put that scrolls.
    localparam int SCROLL_CYCLES = CELLS + COLS + 5;
    localparam int DRAIN_GUARD   = 4 * SCROLL_CYCLES;
    // The limit covers the worst correct run (every word scrolling, plus gaps).
    localparam int RUN_LIMIT_NS  = 40_000_000;

    // ------------------------------------------------------------------
    // Shadow of the screen: predicts each result word and checks the
    // words the block strobes out, oldest first.
    // ------------------------------------------------------------------
    class screen_shadow;
        logic [7:0]  chars [0:CELLS-1];
        logic [7:0]  attrs [0:CELLS-1];
        logic [10:0] cursor;
        t_res        cell_reports [$];
        int          errors;
        int          checked;
        int          scrolls;
        int          end_newlines;
        int          off_screen_reads;
        int          spare_ops;
        int          clears;
        int          fills;

        function new();
            foreach (chars[k]) begin
                chars[k] = '0;
                attrs[k] = '0;
            end
            cursor           = '0;
            errors           = 0;
            checked          = 0;
            scrolls          = 0;
            end_newlines     = 0;
            off_screen_reads = 0;
            spare_ops        = 0;
            clears           = 0;
            fills            = 0;
        endfunction

        // Accepted command word: update the shadow and queue what should come back.
        function void apply_cmd(t_cmd cmd);
            t_res rep;
            rep = '0;
            case (cmd.operation)
                OP_PUT, OP_PUT_COLOR: begin
                    // Cursor parked past the last cell: scroll chars up a row first.
                    if (cursor >= CELLS) begin
                        for (int k = COLS; k < CELLS; k++)
                            chars[k - COLS] = chars[k];
                        for (int k = CELLS - COLS; k < CELLS; k++)
                            chars[k] = CH_BLANK;
                        cursor = 11'(CELLS - COLS);
                        scrolls++;
                        if (cmd.char_code == CH_NEWLINE)
                            end_newlines++;
                    end
                    if (cmd.char_code == CH_NEWLINE) begin
                        cursor = 11'(cursor + COLS - (cursor % COLS));
                    end else begin
                        chars[cursor] = cmd.char_code;
                        if (cmd.operation == OP_PUT_COLOR)
                            attrs[cursor] = cmd.color;
                        cursor = cursor + 11'd1;
                    end
                end
                OP_CLEAR: begin
                    foreach (chars[k])
                        chars[k] = CH_BLANK;
                    cursor = '0;
                    clears++;
                end
                OP_FILL: begin
                    foreach (attrs[k])
                        attrs[k] = cmd.color;
                    fills++;
                end
                OP_READ: begin
                    if (cmd.cell_index < CELLS) begin
                        rep.read_char = chars[cmd.cell_index];
                        rep.read_attr = attrs[cmd.cell_index];
                    end else begin
                        off_screen_reads++;
                    end
                end
                default: spare_ops++;
            endcase
            rep.cursor_cell = cursor;
            cell_reports.push_back(rep);
        endfunction

        // Strobed result word: compare against the oldest prediction.
        function void match_report(t_res got);
            t_res want;
            if (cell_reports.size() == 0) begin
                $display("%0t: unexpected result char=%02h attr=%02h cursor=%0d",
                         $time, got.read_char, got.read_attr, got.cursor_cell);
                errors++;
                return;
            end
            want = cell_reports.pop_front();
            checked++;
            if (got.read_char !== want.read_char || got.read_attr !== want.read_attr ||
                got.cursor_cell !== want.cursor_cell) begin
                $display("%0t: mismatch expected char=%02h attr=%02h cursor=%0d, got char=%02h attr=%02h cursor=%0d",
                         $time, want.read_char, want.read_attr, want.cursor_cell,
                         got.read_char, got.read_attr, got.cursor_cell);
                errors++;
            end
        endfunction

        function int pending();
            return cell_reports.size();
        endfunction

        // End of run: anything still queued never came back.
        function void flag_leftovers();
            if (cell_reports.size() != 0) begin
                $display("%0t: %0d result words never arrived", $time, cell_reports.size());
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    t_cmd  i_cmd;
    logic  busy;
    logic  o_strobe;
    t_res  o_res;

    screen_shadow shadow = new();

    int words_sent  = 0;
    int burst_left  = 0;
    int drain_waits = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    text_console_writer_unit #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // Monitor: sees the same pre-edge values the DUT sees. The result check
    // runs before the new command is noted, so queue order never depends on
    // which process wakes first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                shadow.match_report(o_res);
            if (start && !busy)
                shadow.apply_cmd(i_cmd);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Command word with every field random; callers overwrite what matters.
    function automatic t_cmd noise_cmd(input logic [2:0] op);
        t_cmd c;
        c.operation  = op;
        c.char_code  = 8'($urandom_range(0, 255));
        c.color      = 8'($urandom_range(0, 255));
        c.cell_index = 11'($urandom_range(0, INDEX_MAX));
        return c;
    endfunction

    // Hand one word to the block. The sender runs in bursts with random
    // gaps; start stays high across back-to-back words.
    task automatic send(input t_cmd cmd);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            // Now and then a long burst with no gaps at all.
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    // Pause the sender until every predicted word is back.
    task automatic hold_until_answered();
        start <= 1'b0;
        drain_waits++;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    task automatic put_char(input logic [7:0] ch, input logic colored,
                            input logic [7:0] attr);
        t_cmd c;
        c = noise_cmd(colored ? OP_PUT_COLOR : OP_PUT);
        c.char_code = ch;
        c.color     = attr;
        send(c);
    endtask

    task automatic read_cell(input logic [10:0] idx);
        t_cmd c;
        c = noise_cmd(OP_READ);
        c.cell_index = idx;
        send(c);
    endtask

    // Run of newlines, plain or colored at random; long runs reach the
    // screen end and keep scrolling there.
    task automatic newline_run(input int len);
        for (int k = 0; k < len; k++)
            put_char(CH_NEWLINE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int   pick;
        int   len;
        t_cmd c;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- Directed: field extremes, every op, the corner cases ---
        read_cell(11'd0);                        // zeroed after reset
        put_char(8'h41, 1'b0, 8'h00);
        put_char(8'hFF, 1'b1, 8'hFF);
        put_char(8'h00, 1'b1, 8'h00);
        put_char(CH_NEWLINE, 1'b0, 8'h00);       // to 80, no write
        put_char(CH_NEWLINE, 1'b1, 8'hFF);       // to 160, color ignored
        read_cell(11'd1);
        read_cell(11'(CELLS - 1));               // last cell on screen
        read_cell(11'(CELLS));                   // first cell off screen
        read_cell(INDEX_MAX);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
            c = '1;
            c.operation = 3'(op);
            send(c);
        end
        c = noise_cmd(OP_FILL);
        c.color = 8'hFF;
        send(c);
        read_cell(11'd2);
        c = noise_cmd(OP_FILL);
        c.color = 8'h00;
        send(c);
        send(noise_cmd(OP_CLEAR));               // blanks chars, cursor to 0
        read_cell(11'd0);
        hold_until_answered();

        // --- Random: opens by walking to the screen end so that newlines
        //     and puts there scroll right away ---
        newline_run(CELLS / COLS + 2);
        put_char(8'($urandom_range(8'h21, 8'h7E)), 1'b1, 8'($urandom_range(0, 255)));

        while (words_sent < RANDOM_WORDS + 25) begin
            pick = $urandom_range(0, 99);
            if (pick < 36) begin
                // Line of text, mostly printable bytes, sometimes any byte.
                len = $urandom_range(1, 30);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 4) == 0)
                        c = noise_cmd(3'($urandom_range(OP_PUT, OP_PUT_COLOR)));
                    else begin
                        c = noise_cmd(3'($urandom_range(OP_PUT, OP_PUT_COLOR)));
                        c.char_code = 8'($urandom_range(8'h20, 8'h7E));
                    end
                    send(c);
                end
                if ($urandom_range(0, 1) == 1)
                    put_char(CH_NEWLINE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else if (pick < 54) begin
                newline_run($urandom_range(1, 28));
            end else if (pick < 80) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 4) == 0)
                        read_cell(11'($urandom_range(0, INDEX_MAX)));
                    else
                        read_cell(11'($urandom_range(0, CELLS - 1)));
                end
            end else if (pick < 85) begin
                send(noise_cmd(OP_FILL));
            end else if (pick < 89) begin
                send(noise_cmd(OP_CLEAR));
            end else if (pick < 95) begin
                send(noise_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST))));
            end else begin
                hold_until_answered();
            end
        end
        start <= 1'b0;

        // --- Drain, then let the block sit for one scroll's worth ---
        for (int k = 0; k < DRAIN_GUARD && shadow.pending() != 0; k++)
            @(posedge i_clk);
        repeat (SCROLL_CYCLES) @(posedge i_clk);
        shadow.flag_leftovers();

        $display("tb: %0d commands sent, %0d results checked, %0d drain pauses",
                 words_sent, shadow.checked, drain_waits);
        $display("tb: %0d scrolls (%0d on newline), %0d clears, %0d fills, %0d off-screen reads, %0d spare ops",
                 shadow.scrolls, shadow.end_newlines, shadow.clears, shadow.fills,
                 shadow.off_screen_reads, shadow.spare_ops);
        if (shadow.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing strobe ends here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
hdl/tcw_pkg.sv
hdl/tcw_sequencer.sv
hdl/text_console_writer_unit.sv
sim/text_console_writer_unit_tb.sv
